[rtl/tpls_pkg.sv]
// Shared types and constants of the tile point-light shader.
package tpls_pkg;

    localparam int MAX_LIGHTS = 8;
    localparam int IDX_W      = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
    localparam int CNT_W      = $clog2(MAX_LIGHTS + 1);

    localparam logic [8:0] Q8_ONE  = 9'd256;
    localparam logic [7:0] CH_MAX  = 8'd255;

    // register indexes on the configuration port
    localparam logic [1:0] REG_AMB_RED      = 2'd0;
    localparam logic [1:0] REG_AMB_GREEN    = 2'd1;
    localparam logic [1:0] REG_AMB_BLUE     = 2'd2;
    localparam logic [1:0] REG_AMB_STRENGTH = 2'd3;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_SHADE  = 1'b1;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        reach;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [8:0]         strength;
    } tpls_light_t;

    localparam int LIGHT_W = $bits(tpls_light_t);

    // contribution of one light to the three channels
    typedef struct packed {
        logic       done;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } tpls_term_t;

endpackage

[rtl/tpls_ram.sv]
// Generic single-port-write, registered-read RAM.
module tpls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/tpls_light_unit.sv]
// Per-light unit: distance by iterative square root, falloff by iterative divide.
module tpls_light_unit
    import tpls_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  tpls_light_t        lamp,
    input  logic signed [15:0] tile_x,
    input  logic signed [15:0] tile_y,
    input  logic [8:0]         cap,
    output tpls_term_t         term
);
    typedef enum logic [6:0] {
        U_IDLE = 7'b0000001,
        U_SQ   = 7'b0000010,
        U_SUM  = 7'b0000100,
        U_SQRT = 7'b0001000,
        U_DIV  = 7'b0010000,
        U_MUL  = 7'b0100000,
        U_TERM = 7'b1000000
    } ustate_t;

    ustate_t     state_reg, state_next;
    logic [15:0] adx_reg, ady_reg;
    logic [31:0] sqx_reg, sqy_reg;
    logic [33:0] rad_reg;
    logic [19:0] rem_reg;
    logic [16:0] root_reg;
    logic [17:0] drem_reg;
    logic [16:0] quo_reg;
    logic [4:0]  step_reg;
    logic [15:0] reach_reg;
    logic [7:0]  red_reg, green_reg, blue_reg;
    logic [8:0]  str_reg;
    logic [25:0] sf_reg;
    tpls_term_t  term_reg;

    logic signed [16:0] dx, dy;
    logic [19:0] rem_sh, trial;
    logic [17:0] reach_ext;
    logic [8:0]  s_sat, s_cap;
    logic [33:0] pr, pg, pb;

    always_comb begin
        dx        = {lamp.x[15], lamp.x} - {tile_x[15], tile_x};
        dy        = {lamp.y[15], lamp.y} - {tile_y[15], tile_y};
        rem_sh    = {rem_reg[17:0], rad_reg[33:32]};
        trial     = {1'b0, root_reg, 2'b01};
        reach_ext = {2'b00, reach_reg};
        s_sat     = (str_reg > Q8_ONE) ? Q8_ONE : str_reg;
        s_cap     = (s_sat > cap) ? cap : s_sat;
        pr        = {26'd0, red_reg} * {8'd0, sf_reg};
        pg        = {26'd0, green_reg} * {8'd0, sf_reg};
        pb        = {26'd0, blue_reg} * {8'd0, sf_reg};
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            U_IDLE: if (start) state_next = U_SQ;
            U_SQ:   state_next = U_SUM;
            U_SUM:  state_next = U_SQRT;
            U_SQRT: begin
                if (step_reg == 5'd0) begin
                    state_next = U_DIV;
                end
            end
            U_DIV: begin
                if ({1'b0, root_reg} >= {2'b00, reach_reg}) begin
                    state_next = U_TERM;
                end else if (step_reg == 5'd0) begin
                    state_next = U_MUL;
                end
            end
            U_MUL:  state_next = U_TERM;
            U_TERM: state_next = U_IDLE;
            default: state_next = U_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= U_IDLE;
            term_reg.done <= 1'b0;
        end else begin
            state_reg     <= state_next;
            term_reg.done <= (state_reg == U_TERM);
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            U_IDLE: begin
                adx_reg   <= dx[16] ? 16'(-dx) : dx[15:0];
                ady_reg   <= dy[16] ? 16'(-dy) : dy[15:0];
                reach_reg <= lamp.reach;
                red_reg   <= lamp.red;
                green_reg <= lamp.green;
                blue_reg  <= lamp.blue;
                str_reg   <= lamp.strength;
                sf_reg    <= '0;
            end
            U_SQ: begin
                sqx_reg <= adx_reg * adx_reg;
                sqy_reg <= ady_reg * ady_reg;
            end
            U_SUM: begin
                rad_reg  <= {1'b0, {1'b0, sqx_reg} + {1'b0, sqy_reg}};
                rem_reg  <= '0;
                root_reg <= '0;
                step_reg <= 5'd16;
            end
            U_SQRT: begin
                // one root bit per step
                rad_reg <= {rad_reg[31:0], 2'b00};
                if (rem_sh >= trial) begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[15:0], 1'b1};
                end else begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[15:0], 1'b0};
                end
                if (step_reg == 5'd0) begin
                    drem_reg <= reach_ext;
                    step_reg <= 5'd16;
                end else begin
                    step_reg <= step_reg - 5'd1;
                end
                quo_reg <= '0;
            end
            U_DIV: begin
                // first step seeds the remainder with reach - dist
                if (step_reg == 5'd16 && quo_reg == '0 && drem_reg == reach_ext) begin
                    drem_reg <= 18'(reach_ext - {1'b0, root_reg});
                    quo_reg  <= 17'd1;
                end else begin
                    if (drem_reg >= reach_ext) begin
                        drem_reg <= {drem_reg[16:0] - reach_ext[16:0], 1'b0};
                        quo_reg  <= {quo_reg[15:0], 1'b1};
                    end else begin
                        drem_reg <= {drem_reg[16:0], 1'b0};
                        quo_reg  <= {quo_reg[15:0], 1'b0};
                    end
                    if (quo_reg != '0 || step_reg != 5'd16) begin
                        step_reg <= step_reg - 5'd1;
                    end
                end
            end
            U_MUL: begin
                sf_reg <= {17'd0, s_cap} * {9'd0, quo_reg};
            end
            U_TERM: begin
                term_reg.red   <= pr[31:24];
                term_reg.green <= pg[31:24];
                term_reg.blue  <= pb[31:24];
            end
            default: ;
        endcase
    end

    assign term = term_reg;
endmodule

[rtl/tile_point_light_shader.sv]
// Top level of the tile point-light shader: light table, sequencer, APB registers.
//
// The block holds up to MAX_LIGHTS point lights in one RAM and shades tiles
// against them. An append word (op 0) stores one light in the RAM and
// yields no result; when the table is full the light is dropped. A shade word
// (op 1) starts from the ambient colour scaled by the ambient strength, then
// walks the stored lights in append order, fetching each from the RAM and
// handing it to the light unit, which finds the floor square root of the
// squared distance (17 steps, one root bit each) and the Q.16 linear falloff
// (a seed step and 17 steps of restoring division), then scales colour by
// strength and falloff; each channel sum saturates at 255. A light out of reach
// skips the division. A shade word holds off the input from its acceptance
// until its result moves to the output register; appends do not hold it off.
// The input is taken again while a finished result still waits in the
// output register. Ambient registers sit on an APB port at byte addresses
// 0, 4, 8, 12; write them only while the block is idle.
module tile_point_light_shader
    import tpls_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // input words
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic signed [15:0] s_pos_x,
    input  logic signed [15:0] s_pos_y,
    input  logic [15:0]        s_reach,
    input  logic [7:0]         s_red_in,
    input  logic [7:0]         s_green_in,
    input  logic [7:0]         s_blue_in,
    input  logic [8:0]         s_strength_in,
    // result words
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_lit_red,
    output logic [7:0]         m_lit_green,
    output logic [7:0]         m_lit_blue,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FETCH = 5'b00010,
        ST_LOAD  = 5'b00100,
        ST_RUN   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   k_reg;
    logic [7:0]         amb_r_reg, amb_g_reg, amb_b_reg;
    logic [8:0]         amb_s_reg;
    logic [7:0]         acc_r_reg, acc_g_reg, acc_b_reg;
    logic signed [15:0] tile_x_reg, tile_y_reg;
    logic [8:0]         cap_reg;
    logic               m_valid_reg;
    logic [7:0]         out_r_reg, out_g_reg, out_b_reg;

    logic               s_take, cfg_write, ram_we;
    logic [8:0]         amb;
    logic [16:0]        base_r, base_g, base_b;
    logic [8:0]         sum_r, sum_g, sum_b;
    logic [1:0]         reg_idx;
    tpls_light_t        wr_light, rd_light;
    logic [LIGHT_W-1:0] rd_bits;
    tpls_term_t         term;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_take    = s_valid && s_ready;
    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // clamp ambient strength to one; lights get what is left
    assign amb    = (amb_s_reg > Q8_ONE) ? Q8_ONE : amb_s_reg;
    assign base_r = {9'd0, amb_r_reg} * {8'd0, amb};
    assign base_g = {9'd0, amb_g_reg} * {8'd0, amb};
    assign base_b = {9'd0, amb_b_reg} * {8'd0, amb};
    assign sum_r  = {1'b0, acc_r_reg} + {1'b0, term.red};
    assign sum_g  = {1'b0, acc_g_reg} + {1'b0, term.green};
    assign sum_b  = {1'b0, acc_b_reg} + {1'b0, term.blue};

    always_comb begin
        wr_light.x        = s_pos_x;
        wr_light.y        = s_pos_y;
        wr_light.reach    = s_reach;
        wr_light.red      = s_red_in;
        wr_light.green    = s_green_in;
        wr_light.blue     = s_blue_in;
        wr_light.strength = s_strength_in;
    end

    // append writes the next free entry; drop when full
    assign ram_we   = s_take && (s_op == OP_APPEND) && (count_reg < CNT_W'(MAX_LIGHTS));
    assign rd_light = tpls_light_t'(rd_bits);

    tpls_ram #(
        .WIDTH (LIGHT_W),
        .DEPTH (MAX_LIGHTS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (wr_light),
        .raddr (k_reg[IDX_W-1:0]),
        .rdata (rd_bits)
    );

    tpls_light_unit u_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == ST_LOAD),
        .lamp    (rd_light),
        .tile_x  (tile_x_reg),
        .tile_y  (tile_y_reg),
        .cap     (cap_reg),
        .term    (term)
    );

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // load a finished result, or drop the one just taken
            if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (ram_we) begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    if (s_take && s_op == OP_SHADE) begin
                        k_reg     <= '0;
                        state_reg <= ST_FETCH;
                    end
                end
                ST_FETCH: begin
                    // read issued here; data arrives next cycle
                    state_reg <= (k_reg == count_reg) ? ST_DONE : ST_LOAD;
                end
                ST_LOAD: state_reg <= ST_RUN;
                ST_RUN: begin
                    if (term.done) begin
                        k_reg     <= k_reg + CNT_W'(1);
                        state_reg <= ST_FETCH;
                    end
                end
                ST_DONE: begin
                    // hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_take && s_op == OP_SHADE) begin
            tile_x_reg <= s_pos_x;
            tile_y_reg <= s_pos_y;
            cap_reg    <= Q8_ONE - amb;
            acc_r_reg  <= base_r[15:8];
            acc_g_reg  <= base_g[15:8];
            acc_b_reg  <= base_b[15:8];
        end else if (state_reg == ST_RUN && term.done) begin
            acc_r_reg <= sum_r[8] ? CH_MAX : sum_r[7:0];
            acc_g_reg <= sum_g[8] ? CH_MAX : sum_g[7:0];
            acc_b_reg <= sum_b[8] ? CH_MAX : sum_b[7:0];
        end
        if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
            out_r_reg <= acc_r_reg;
            out_g_reg <= acc_g_reg;
            out_b_reg <= acc_b_reg;
        end
    end

    // ambient registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amb_r_reg <= '0;
            amb_g_reg <= '0;
            amb_b_reg <= '0;
            amb_s_reg <= Q8_ONE;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_AMB_RED:      amb_r_reg <= pwdata[7:0];
                REG_AMB_GREEN:    amb_g_reg <= pwdata[7:0];
                REG_AMB_BLUE:     amb_b_reg <= pwdata[7:0];
                REG_AMB_STRENGTH: amb_s_reg <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_AMB_RED:      prdata = {24'd0, amb_r_reg};
            REG_AMB_GREEN:    prdata = {24'd0, amb_g_reg};
            REG_AMB_BLUE:     prdata = {24'd0, amb_b_reg};
            REG_AMB_STRENGTH: prdata = {23'd0, amb_s_reg};
            default:          prdata = '0;
        endcase
    end

    assign m_valid     = m_valid_reg;
    assign m_lit_red   = out_r_reg;
    assign m_lit_green = out_g_reg;
    assign m_lit_blue  = out_b_reg;
endmodule

[rtl/tpls_checker.sv]
// Port-level checks on the tile point-light shader, bound to the top level.
module tpls_checker
    import tpls_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       s_op,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_lit_red,
    input logic [7:0] m_lit_green,
    input logic [7:0] m_lit_blue,
    input logic       pready
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_lit_red)
            && $stable(m_lit_green) && $stable(m_lit_blue))
        else $error("result word changed while stalled");

    a_shade_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op == OP_SHADE |=> !s_ready)
        else $error("input taken again before shade finished");

    a_append_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op == OP_APPEND && !m_valid |=> !m_valid)
        else $error("append produced a result word");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready dropped");
endmodule

bind tile_point_light_shader tpls_checker u_tpls_checker (.*);

[tb/sv/tb_tile_point_light_shader.sv]
// Self-checking testbench of the tile point-light shader: stimulus, predictor and scoreboard.
module tb_tile_point_light_shader;
    import tpls_pkg::*;

    // One input word as the sender offers it.
    typedef struct {
        logic              op;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]       reach;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic [8:0]        strength;
    } tile_word_t;

    // One shaded color as the block returns it.
    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } tile_rgb_t;

    // Shading predictor: its own copy of the light table and the ambient
    // registers, and the queue of colors still owed by the block.
    class shade_scoreboard;
        int          lamp_x [MAX_LIGHTS];
        int          lamp_y [MAX_LIGHTS];
        int unsigned lamp_reach [MAX_LIGHTS];
        int unsigned lamp_red [MAX_LIGHTS];
        int unsigned lamp_green [MAX_LIGHTS];
        int unsigned lamp_blue [MAX_LIGHTS];
        int unsigned lamp_strength [MAX_LIGHTS];
        int          lamp_count;
        int unsigned amb_red, amb_green, amb_blue, amb_strength;
        tile_rgb_t   owed_colors[$];

        function new();
            lamp_count   = 0;
            amb_red      = 0;
            amb_green    = 0;
            amb_blue     = 0;
            amb_strength = 256;
        endfunction

        function void set_ambient(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_AMB_RED:      amb_red      = {24'd0, value[7:0]};
                REG_AMB_GREEN:    amb_green    = {24'd0, value[7:0]};
                REG_AMB_BLUE:     amb_blue     = {24'd0, value[7:0]};
                REG_AMB_STRENGTH: amb_strength = {23'd0, value[8:0]};
                default: ;
            endcase
        endfunction

        function longint unsigned floor_root(longint unsigned n);
            longint unsigned root;
            longint unsigned probe;
            root  = 0;
            probe = 64'd1 << 62;
            while (probe > n) probe = probe >> 2;
            while (probe != 0) begin
                if (n >= root + probe) begin
                    n    = n - (root + probe);
                    root = (root >> 1) + probe;
                end else begin
                    root = root >> 1;
                end
                probe = probe >> 2;
            end
            return root;
        endfunction

        function int unsigned sat_sum(int unsigned acc, longint unsigned add);
            longint unsigned s;
            s = acc + add;
            return (s > 255) ? 255 : 32'(s);
        endfunction

        function tile_rgb_t shade_tile(int px, int py);
            int unsigned     amb, cap, r, g, b, s;
            longint          dx, dy;
            longint unsigned radius, fall, sf;
            tile_rgb_t       res;
            amb = (amb_strength > 256) ? 256 : amb_strength;
            cap = 256 - amb;
            r = (amb_red * amb) >> 8;
            g = (amb_green * amb) >> 8;
            b = (amb_blue * amb) >> 8;
            for (int k = 0; k < lamp_count; k++) begin
                dx     = lamp_x[k] - px;
                dy     = lamp_y[k] - py;
                radius = floor_root(dx * dx + dy * dy);
                if (radius >= lamp_reach[k]) continue;
                fall = ((lamp_reach[k] - radius) << 16) / lamp_reach[k];
                s = (lamp_strength[k] > 256) ? 256 : lamp_strength[k];
                if (s > cap) s = cap;
                sf = s * fall;
                r = sat_sum(r, (lamp_red[k] * sf) >> 24);
                g = sat_sum(g, (lamp_green[k] * sf) >> 24);
                b = sat_sum(b, (lamp_blue[k] * sf) >> 24);
            end
            res.red   = r[7:0];
            res.green = g[7:0];
            res.blue  = b[7:0];
            return res;
        endfunction

        // Note an accepted input word.
        function void note_input(tile_word_t w);
            if (w.op == OP_APPEND) begin
                if (lamp_count < MAX_LIGHTS) begin
                    lamp_x[lamp_count]        = w.x;
                    lamp_y[lamp_count]        = w.y;
                    lamp_reach[lamp_count]    = w.reach;
                    lamp_red[lamp_count]      = w.red;
                    lamp_green[lamp_count]    = w.green;
                    lamp_blue[lamp_count]     = w.blue;
                    lamp_strength[lamp_count] = w.strength;
                    lamp_count++;
                end
            end else begin
                owed_colors.insert(owed_colors.size(), shade_tile(w.x, w.y));
            end
        endfunction

        // Check one accepted result against the oldest owed color.
        function void check_result(tile_rgb_t got, ref string notes[$]);
            tile_rgb_t want;
            if (owed_colors.size() == 0) begin
                notes.insert(notes.size(),
                             $sformatf("result %0d/%0d/%0d with nothing owed",
                                       got.red, got.green, got.blue));
                return;
            end
            want = owed_colors.pop_front();
            if (got.red !== want.red)
                notes.insert(notes.size(),
                             $sformatf("red got %0d want %0d", got.red, want.red));
            if (got.green !== want.green)
                notes.insert(notes.size(),
                             $sformatf("green got %0d want %0d", got.green, want.green));
            if (got.blue !== want.blue)
                notes.insert(notes.size(),
                             $sformatf("blue got %0d want %0d", got.blue, want.blue));
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_op;
    logic signed [15:0] s_pos_x;
    logic signed [15:0] s_pos_y;
    logic [15:0]        s_reach;
    logic [7:0]         s_red_in;
    logic [7:0]         s_green_in;
    logic [7:0]         s_blue_in;
    logic [8:0]         s_strength_in;
    logic               m_valid;
    logic               m_ready;
    logic [7:0]         m_lit_red;
    logic [7:0]         m_lit_green;
    logic [7:0]         m_lit_blue;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    shade_scoreboard sb;
    int  mismatch_count;
    bit  no_idle;       // drop all gaps on both sides while set
    bit  hold_request;  // ask the receiver for one long hold-off

    // Allow a margin past a full-table shade.
    localparam int DRAIN_CYCLES = 500;
    localparam int HOLD_CYCLES  = 3000;

    tile_point_light_shader u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_reach       (s_reach),
        .s_red_in      (s_red_in),
        .s_green_in    (s_green_in),
        .s_blue_in     (s_blue_in),
        .s_strength_in (s_strength_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_lit_red     (m_lit_red),
        .m_lit_green   (m_lit_green),
        .m_lit_blue    (m_lit_blue),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard limit: stop the run and report a failure if it never finishes.
    initial begin
        #40000000;
        $display("Mismatches found");
        $finish;
    end

    task automatic report_mismatch(string msg);
        $display("mismatch @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Write one ambient register: setup cycle, then access cycle.
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_ambient(idx, value);
    endtask

    task automatic set_ambient_all(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                   logic [8:0] s);
        write_reg(REG_AMB_RED, {24'd0, r});
        write_reg(REG_AMB_GREEN, {24'd0, g});
        write_reg(REG_AMB_BLUE, {24'd0, b});
        write_reg(REG_AMB_STRENGTH, {23'd0, s});
    endtask

    // Offer one word after a random gap; hold it until accepted. Valid is
    // lowered only when a gap follows, so back-to-back words keep it high.
    task automatic send_word(tile_word_t w);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        repeat (gap) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_op          <= w.op;
        s_pos_x       <= w.x;
        s_pos_y       <= w.y;
        s_reach       <= w.reach;
        s_red_in      <= w.red;
        s_green_in    <= w.green;
        s_blue_in     <= w.blue;
        s_strength_in <= w.strength;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(w);
    endtask

    function automatic tile_word_t make_light(int x, int y, int reach, int r, int g,
                                              int b, int s);
        tile_word_t w;
        w.op = OP_APPEND;
        w.x = 16'(x);
        w.y = 16'(y);
        w.reach = 16'(reach);
        w.red = 8'(r);
        w.green = 8'(g);
        w.blue = 8'(b);
        w.strength = 9'(s);
        return w;
    endfunction

    function automatic tile_word_t make_shade(int x, int y);
        tile_word_t w;
        w = make_light(x, y, $urandom, $urandom, $urandom, $urandom, $urandom);
        w.op = OP_SHADE;
        return w;
    endfunction

    function automatic int clip16(int v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    // Random word: mostly tiles aimed near some light, up to a quarter past its reach
    // on each axis, some tiles anywhere, and some appends that a full table drops.
    function automatic tile_word_t random_word();
        int pick, k, span;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return make_light($urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom);
        if (pick < 22 || sb.lamp_count == 0)
            return make_shade($urandom, $urandom);
        k    = $urandom_range(0, sb.lamp_count - 1);
        span = sb.lamp_reach[k] + sb.lamp_reach[k] / 4 + 2;
        if (span > 40000) span = 40000;
        return make_shade(clip16(sb.lamp_x[k] + $urandom_range(0, 2 * span) - span),
                          clip16(sb.lamp_y[k] + $urandom_range(0, 2 * span) - span));
    endfunction

    // Drop valid, then wait until every owed color has come back.
    task automatic drain_block();
        s_valid <= 1'b0;
        while (sb.owed_colors.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Receiver: stall a random count before each word, once a long stretch.
    initial begin
        int        stall;
        string     notes[$];
        tile_rgb_t got;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                stall = HOLD_CYCLES;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 9);
            end
            repeat (stall) begin
                m_ready <= 1'b0;
                @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            got.red   = m_lit_red;
            got.green = m_lit_green;
            got.blue  = m_lit_blue;
            notes.delete();
            sb.check_result(got, notes);
            foreach (notes[i]) report_mismatch(notes[i]);
        end
    end

    initial begin
        tile_word_t w;
        sb = new();
        mismatch_count = 0;
        no_idle = 1'b0;
        hold_request = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_op = OP_APPEND;
        s_pos_x = '0;
        s_pos_y = '0;
        s_reach = '0;
        s_red_in = '0;
        s_green_in = '0;
        s_blue_in = '0;
        s_strength_in = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty table at reset ambient, then ambient at zero strength.
        send_word(make_shade(0, 0));
        drain_block();
        set_ambient_all(8'd255, 8'd0, 8'd128, 9'd0);
        send_word(make_shade(-32768, 32767));
        // Corner light with full reach and full color.
        send_word(make_light(-32768, -32768, 65535, 255, 255, 255, 256));
        // Opposite corner with the smallest nonzero reach and strength above one.
        send_word(make_light(32767, 32767, 1, 255, 0, 128, 300));
        // Zero reach never adds.
        send_word(make_light(0, 0, 0, 255, 255, 255, 256));
        send_word(make_light(100, -200, 500, 17, 200, 90, 128));
        send_word(make_light(0, 0, 65535, 200, 100, 50, 511));
        send_word(make_shade(-32768, -32768));  // zero distance: full falloff
        send_word(make_shade(32767, 32767));
        send_word(make_shade(32767, -32768));
        send_word(make_shade(100, -200));
        send_word(make_shade(0, 0));
        for (int i = 0; i < 3; i++)
            send_word(make_light($urandom_range(0, 4000) - 2000,
                                 $urandom_range(0, 4000) - 2000,
                                 $urandom_range(1, 3000), $urandom, $urandom,
                                 $urandom, $urandom_range(0, 256)));
        // Table full: these two appends are dropped.
        send_word(make_light(5, 5, 65535, 255, 255, 255, 256));
        send_word(make_light(-1, -1, 0, 0, 0, 0, 0));
        send_word(make_shade(5, 5));
        send_word(make_shade(600, -200));
        drain_block();

        // Random phases, each under a different ambient setting.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_ambient_all(8'd0, 8'd0, 8'd0, 9'd256);
                1: set_ambient_all(8'd255, 8'd255, 8'd255, 9'd511);
                2: set_ambient_all(8'($urandom), 8'($urandom), 8'($urandom),
                                   9'($urandom_range(0, 256)));
                default: set_ambient_all(8'($urandom), 8'($urandom), 8'($urandom),
                                         9'($urandom));
            endcase
            for (int i = 0; i < 400; i++) begin
                if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
                // Hold off the receiver while the sender keeps offering tiles.
                if (phase == 1 && i == 150) begin
                    no_idle = 1'b1;
                    hold_request = 1'b1;
                end
                w = random_word();
                send_word(w);
            end
            no_idle = 1'b0;
            drain_block();
        end

        foreach (sb.owed_colors[i])
            report_mismatch("expected color never returned");
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/tpls_pkg.sv
rtl/tpls_ram.sv
rtl/tpls_light_unit.sv
rtl/tile_point_light_shader.sv
rtl/tpls_checker.sv
tb/sv/tb_tile_point_light_shader.sv
